/* design/isf_pkg.sv */
// Shared types, constants and CRC functions of the segment framer.
package isf_pkg;

    localparam int SEGMENT_WORDS_DEF = 1024;

    localparam int COUNT_W = 14;
    localparam int INDEX_W = 10;
    localparam int WORD_W  = 16;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    localparam logic [WORD_W-1:0] HDR_MARK   = 16'h8000;
    localparam logic [WORD_W-1:0] CRC_INIT   = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY   = 16'h1021;
    localparam logic [WORD_W-1:0] CMD_SELECT = 16'h060C;
    localparam logic [WORD_W-1:0] CMD_READ   = 16'h040D;
    localparam logic [WORD_W-1:0] CMD_WRITE  = 16'h060D;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_BEGIN = 3'd0;
    localparam kind_t KIND_READ  = 3'd1;
    localparam kind_t KIND_WRITE = 3'd2;
    localparam kind_t KIND_END   = 3'd3;
    localparam kind_t KIND_OVF   = 3'd4;

    // One classified command on its way from the front to the back.
    // For an end command, data carries the rewritten header word.
    typedef struct packed {
        kind_t               kind;
        logic [WORD_W-1:0]   addr;
        logic [WORD_W-1:0]   data;
        logic [INDEX_W-1:0]  base;
    } entry_t;

    // CRC-16/CCITT byte table entry, MSB first.
    function automatic logic [WORD_W-1:0] crc_tbl(input logic [7:0] idx);
        logic [WORD_W-1:0] c;
        c = {idx, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[WORD_W-1]) begin
                c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[WORD_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Fold one 16-bit word into the CRC, high byte first.
    function automatic logic [WORD_W-1:0] crc16_word(input logic [WORD_W-1:0] crc,
                                                     input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] c1;
        c1 = {crc[7:0], 8'h00} ^ crc_tbl(crc[15:8] ^ w[15:8]);
        return {c1[7:0], 8'h00} ^ crc_tbl(c1[15:8] ^ w[7:0]);
    endfunction

endpackage

/* design/isf_front.sv */
// Command front: accepts items, tracks the payload count and classifies each command.
module isf_front #(
    parameter int SEGMENT_WORDS = isf_pkg::SEGMENT_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  logic [1:0]           opcode,
    input  logic [15:0]          reg_address,
    input  logic [15:0]          write_value,
    input  logic                 q_full,
    output logic                 push,
    output isf_pkg::entry_t      push_entry
);
    import isf_pkg::*;

    // Largest payload count that still leaves room for one more command and the CRC.
    localparam int                 LIMIT_INT = SEGMENT_WORDS - 7;
    localparam logic [COUNT_W:0]   LIMIT     = (COUNT_W+1)'(LIMIT_INT);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_plus1;
    logic               full_seg;

    assign cmd_stall   = q_full;
    assign push        = cmd_valid && !q_full;
    assign count_plus1 = count_reg + COUNT_W'(1);
    assign full_seg    = {1'b0, count_reg} > LIMIT;

    always_comb
    begin
        push_entry.addr = reg_address;
        push_entry.data = write_value;
        push_entry.base = count_reg[INDEX_W-1:0] + INDEX_W'(2);
        push_entry.kind = KIND_BEGIN;
        count_next      = count_reg;
        unique case (opcode)
            OP_BEGIN:
            begin
                push_entry.kind = KIND_BEGIN;
                count_next      = '0;
            end
            OP_READ, OP_WRITE:
            begin
                if (full_seg) begin
                    push_entry.kind = KIND_OVF;
                end else begin
                    push_entry.kind = (opcode == OP_READ) ? KIND_READ : KIND_WRITE;
                    count_next      = count_reg + COUNT_W'(4);
                end
            end
            OP_END:
            begin
                push_entry.kind = KIND_END;
                push_entry.data = HDR_MARK + {{(WORD_W-COUNT_W){1'b0}}, count_plus1};
                count_next      = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else if (push) begin
            count_reg <= count_next;
        end
    end

endmodule

/* design/isf_queue.sv */
// Two-entry queue between the command front and the word back.
module isf_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  isf_pkg::entry_t      push_entry,
    output logic                 full,
    input  logic                 pop,
    output logic                 head_valid,
    output isf_pkg::entry_t      head_entry
);
    import isf_pkg::*;

    entry_t     slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       do_pop;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !do_pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (do_pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/isf_back.sv */
// Word back: steps through each queued command, emits its words and keeps the CRC.
module isf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  isf_pkg::entry_t      head_entry,
    output logic                 pop,
    output logic                 word_valid,
    input  logic                 word_stall,
    output logic [15:0]          word_value,
    output logic [9:0]           word_index,
    output logic                 overflow,
    output logic                 last_of_run
);
    import isf_pkg::*;

    logic [1:0]          step_reg;
    logic [WORD_W-1:0]   crc_reg;
    logic [WORD_W-1:0]   crc_next;
    logic                valid_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic                ovf_reg;
    logic                last_reg;

    logic [WORD_W-1:0]   value_next;
    logic [INDEX_W-1:0]  index_next;
    logic                ovf_next;
    logic                last_next;
    logic                load;
    logic                is_read;

    assign load    = head_valid && (!valid_reg || !word_stall);
    assign pop     = load && last_next;
    assign is_read = (head_entry.kind == KIND_READ);

    always_comb
    begin
        value_next = '0;
        index_next = '0;
        ovf_next   = 1'b0;
        last_next  = 1'b1;
        crc_next   = crc_reg;
        unique case (head_entry.kind)
            KIND_BEGIN:
            begin
                value_next = step_reg[0] ? '0 : HDR_MARK;
                index_next = {{(INDEX_W-1){1'b0}}, step_reg[0]};
                last_next  = step_reg[0];
                if (step_reg[0]) begin
                    crc_next = CRC_INIT;
                end
            end
            KIND_READ, KIND_WRITE:
            begin
                unique case (step_reg)
                    2'd0: value_next = CMD_SELECT;
                    2'd1: value_next = head_entry.addr;
                    2'd2: value_next = is_read ? CMD_READ : CMD_WRITE;
                    2'd3: value_next = is_read ? '0 : head_entry.data;
                endcase
                index_next = head_entry.base + INDEX_W'(step_reg);
                last_next  = (step_reg == 2'd3);
                crc_next   = crc16_word(crc_reg, value_next);
            end
            KIND_END:
            begin
                value_next = step_reg[0] ? head_entry.data : crc_reg;
                index_next = step_reg[0] ? '0 : head_entry.base;
                last_next  = step_reg[0];
                if (step_reg[0]) begin
                    crc_next = CRC_INIT;
                end
            end
            KIND_OVF:
            begin
                ovf_next = 1'b1;
            end
            default:
            begin
                last_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg  <= 2'd0;
            crc_reg   <= CRC_INIT;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                crc_reg   <= crc_next;
                step_reg  <= last_next ? 2'd0 : step_reg + 2'd1;
            end else if (!word_stall) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            value_reg <= value_next;
            index_reg <= index_next;
            ovf_reg   <= ovf_next;
            last_reg  <= last_next;
        end
    end

    assign word_valid  = valid_reg;
    assign word_value  = value_reg;
    assign word_index  = index_reg;
    assign overflow    = ovf_reg;
    assign last_of_run = last_reg;

endmodule

/* design/io_segment_framer_crc16.sv */
// Top level of the command segment framer with running CRC-16/CCITT-FALSE.
//
// Usage:
//   The command channel (cmd_valid / cmd_stall) takes one item per unstalled
//   cycle carrying opcode, reg_address and write_value. Begin yields two words,
//   read and write yield four, end yields the CRC word and the rewritten header;
//   a read or write that does not fit in SEGMENT_WORDS yields a single overflow
//   word instead. The word channel (word_valid / word_stall) delivers one segment
//   word per unstalled cycle with its index; last_of_run marks an item's last word.
//
// Timing:
//   When the path is empty, an accepted item passes through the queue slot and
//   then the output register before its first word is on the word ports.
//   The word back emits one word a cycle while word_stall is low. The word
//   back's output rate sets throughput; a two-entry queue lets the front keep
//   accepting items while the back works through earlier ones.
//
// Reset clears the payload count, sets the CRC to 0xFFFF and empties the queue
// and output register. While word_stall is high the output word holds; the
// queue fills and then cmd_stall rises until words drain again.
module io_segment_framer_crc16 #(
    parameter int SEGMENT_WORDS = isf_pkg::SEGMENT_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] reg_address,
    input  logic [15:0] write_value,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [15:0] word_value,
    output logic [9:0]  word_index,
    output logic        overflow,
    output logic        last_of_run
);
    import isf_pkg::*;

    // Front to queue.
    logic   push;
    entry_t push_entry;
    logic   q_full;

    // Queue to back.
    logic   head_valid;
    entry_t head_entry;
    logic   pop;

    // Classify commands and keep the payload count.
    isf_front #(
        .SEGMENT_WORDS (SEGMENT_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .opcode      (opcode),
        .reg_address (reg_address),
        .write_value (write_value),
        .q_full      (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    // Decouple the two sides.
    isf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Expand each command into words and advance the CRC.
    isf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word_value  (word_value),
        .word_index  (word_index),
        .overflow    (overflow),
        .last_of_run (last_of_run)
    );

endmodule

/* design/isf_checker.sv */
// Port-level checks of the segment framer and their binding to the top level.
module isf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_stall,
    input logic [1:0]  opcode,
    input logic [15:0] reg_address,
    input logic [15:0] write_value,
    input logic        word_valid,
    input logic        word_stall,
    input logic [15:0] word_value,
    input logic [9:0]  word_index,
    input logic        overflow,
    input logic        last_of_run
);

    // A stalled command item holds.
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(opcode)
            && $stable(reg_address) && $stable(write_value))
        else $error("stalled command item changed");

    // A stalled word holds.
    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && word_stall |=> word_valid && $stable(word_value)
            && $stable(word_index) && $stable(last_of_run))
        else $error("stalled word changed");

    // A refusal is a single zero word at index zero.
    a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && overflow |-> last_of_run && (word_value == 16'h0000)
            && (word_index == 10'd0))
        else $error("malformed overflow word");

    // The words of one item follow each other without a gap.
    a_run_dense: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_stall && !last_of_run |=> word_valid)
        else $error("gap inside an item's words");

    // Only the final word of an item carries the overflow flag.
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !last_of_run |-> !overflow)
        else $error("overflow on a non-final word");

endmodule

bind io_segment_framer_crc16 isf_checker u_isf_checker (.*);

/* tb/sv/tb.sv */
// Self-checking testbench for the command segment framer with running CRC-16.
`timescale 1ns / 1ps

module tb;
    import isf_pkg::*;

    localparam int FRAME_WORDS      = SEGMENT_WORDS_DEF;
    localparam int DIRECTED_ROWS    = 19;
    localparam int ITEMS_PER_PHASE  = 52;
    localparam int FILL_ADDS        = 258;
    localparam int QUIET_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 12;

    // One segment word as the word channel delivers it.
    typedef struct packed {
        logic [15:0] value;
        logic [9:0]  index;
        logic        ovf;
        logic        last;
    } seg_word_t;

    // One directed item; where pinned is set, the first word of the item is
    // typed in here instead of being taken from the predictor.
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] adr;
        logic [15:0] dat;
        logic        pinned;
        logic [15:0] pin_value;
        logic [9:0]  pin_index;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [1:0]  opcode;
    logic [15:0] reg_address;
    logic [15:0] write_value;
    logic        word_valid;
    logic        word_stall;
    logic [15:0] word_value;
    logic [9:0]  word_index;
    logic        overflow;
    logic        last_of_run;

    // Predictor state: payload words so far and the CRC over them.
    logic [13:0] seg_len;
    logic [15:0] seg_crc;
    seg_word_t   pending_words [$];
    seg_word_t   pinned_word;

    // Pinned expectation of the item currently on the command channel.
    logic        cur_pinned;
    logic [15:0] cur_pin_value;
    logic [9:0]  cur_pin_index;

    int          errors;
    int          items_sent;
    int          quiet_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    // Phases of idling: none, sender only, receiver only, both.
    int          phase_send_pct  [4] = '{0, 49, 0, 21};
    int          phase_stall_pct [4] = '{0, 0, 49, 21};

    dir_row_t directed_rows [DIRECTED_ROWS] = '{
        // end right after reset: empty segment, CRC still at its start value
        '{OP_END,   16'h0000, 16'h0000, 1'b1, 16'hFFFF, 10'd2},
        '{OP_BEGIN, 16'h0000, 16'h0000, 1'b1, 16'h8000, 10'd0},
        // end of an empty segment after begin
        '{OP_END,   16'h0000, 16'h0000, 1'b1, 16'hFFFF, 10'd2},
        // adds with no begin work from the empty segment
        '{OP_READ,  16'h0000, 16'hFFFF, 1'b1, 16'h060C, 10'd2},
        '{OP_WRITE, 16'hFFFF, 16'hFFFF, 1'b1, 16'h060C, 10'd6},
        '{OP_END,   16'h0000, 16'h0000, 1'b0, 16'h0000, 10'd0},
        '{OP_BEGIN, 16'hFFFF, 16'hFFFF, 1'b1, 16'h8000, 10'd0},
        '{OP_READ,  16'hFFFF, 16'h0000, 1'b1, 16'h060C, 10'd2},
        '{OP_WRITE, 16'h0000, 16'h0000, 1'b1, 16'h060C, 10'd6},
        '{OP_WRITE, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 10'd0},
        '{OP_WRITE, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 10'd0},
        '{OP_READ,  16'h8001, 16'h7FFE, 1'b0, 16'h0000, 10'd0},
        '{OP_WRITE, 16'h0001, 16'h8000, 1'b0, 16'h0000, 10'd0},
        '{OP_END,   16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 10'd0},
        '{OP_READ,  16'h1234, 16'h5678, 1'b1, 16'h060C, 10'd2},
        // begin in the middle of a segment drops the payload so far
        '{OP_BEGIN, 16'h0000, 16'h0000, 1'b1, 16'h8000, 10'd0},
        '{OP_WRITE, 16'h00FF, 16'hFF00, 1'b1, 16'h060C, 10'd2},
        '{OP_END,   16'h0000, 16'h0000, 1'b0, 16'h0000, 10'd0},
        '{OP_READ,  16'h0000, 16'h0000, 1'b1, 16'h060C, 10'd2}
    };

    io_segment_framer_crc16 #(
        .SEGMENT_WORDS(FRAME_WORDS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .opcode     (opcode),
        .reg_address(reg_address),
        .write_value(write_value),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word_value (word_value),
        .word_index (word_index),
        .overflow   (overflow),
        .last_of_run(last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Fold one word into the CRC one bit at a time, MSB first.
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [15:0] w);
        logic [15:0] c;
        logic        top;
        c = crc;
        for (int b = 15; b >= 0; b--)
        begin
            top = c[15] ^ w[b];
            c = {c[14:0], 1'b0};
            if (top)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic expect_word(input logic [15:0] value, input int index,
                               input logic ovf, input logic last);
        seg_word_t w;
        w.value = value;
        w.index = index[9:0];
        w.ovf   = ovf;
        w.last  = last;
        pending_words.push_back(w);
    endtask

    // Work out the words one accepted item causes and advance the predictor.
    task automatic frame_command(input logic [1:0] op, input logic [15:0] adr,
                                 input logic [15:0] dat, output int n);
        logic [15:0] cmd_words [4];
        int          base;
        base = 2 + int'(seg_len);
        if (op == OP_BEGIN)
        begin
            expect_word(HDR_MARK, 0, 1'b0, 1'b0);
            expect_word(16'h0000, 1, 1'b0, 1'b1);
            seg_len = '0;
            seg_crc = CRC_INIT;
            n = 2;
        end
        else if (op == OP_END)
        begin
            // Emit the CRC, then rewrite the header with the length plus one.
            expect_word(seg_crc, base, 1'b0, 1'b0);
            expect_word(HDR_MARK + {2'b00, seg_len + 14'd1}, 0, 1'b0, 1'b1);
            seg_len = '0;
            seg_crc = CRC_INIT;
            n = 2;
        end
        else if (base + 4 + 1 > FRAME_WORDS)
        begin
            // Refuse the add: a single overflow word, state untouched.
            expect_word(16'h0000, 0, 1'b1, 1'b1);
            n = 1;
        end
        else
        begin
            cmd_words[0] = CMD_SELECT;
            cmd_words[1] = adr;
            cmd_words[2] = (op == OP_READ) ? CMD_READ : CMD_WRITE;
            cmd_words[3] = (op == OP_READ) ? 16'h0000 : dat;
            for (int k = 0; k < 4; k++)
            begin
                expect_word(cmd_words[k], base + k, 1'b0, k == 3);
                seg_crc = crc_ccitt_step(seg_crc, cmd_words[k]);
            end
            seg_len = seg_len + 14'd4;
            n = 4;
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
        errors++;
    endtask

    // Compare one delivered word with the oldest expectation.
    task automatic check_word();
        seg_word_t w;
        if (pending_words.size() == 0)
        begin
            report_mismatch("word with nothing expected", 0, word_value);
        end
        else
        begin
            w = pending_words.pop_front();
            if (word_value !== w.value)
                report_mismatch("word_value", w.value, word_value);
            if (word_index !== w.index)
                report_mismatch("word_index", w.index, word_index);
            if (overflow !== w.ovf)
                report_mismatch("overflow", w.ovf, overflow);
            if (last_of_run !== w.last)
                report_mismatch("last_of_run", w.last, last_of_run);
        end
    endtask

    // Sample both channels at the rising edge. Check words before predicting,
    // since no word can come from an item accepted at the same edge.
    always @(posedge clk)
    begin
        int n;
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                check_word();
            end
            if (cmd_valid && !cmd_stall)
            begin
                frame_command(opcode, reg_address, write_value, n);
                if (cur_pinned)
                begin
                    // Replace the predicted first word with the typed-in one.
                    pinned_word = pending_words[pending_words.size() - n];
                    pinned_word.value = cur_pin_value;
                    pinned_word.index = cur_pin_index;
                    pending_words[pending_words.size() - n] = pinned_word;
                end
            end
            if ((word_valid && !word_stall) || (cmd_valid && !cmd_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Drive the receiver's stall at the falling edge, one update per cycle.
    always @(negedge clk)
    begin
        word_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Present one item at a falling edge and hold it until it is accepted.
    // Call at a falling edge; return at the falling edge after acceptance.
    task automatic send_item(input logic [1:0] op, input logic [15:0] adr,
                             input logic [15:0] dat, input logic pinned,
                             input logic [15:0] pin_value, input logic [9:0] pin_index);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        opcode        = op;
        reg_address   = adr;
        write_value   = dat;
        cur_pinned    = pinned;
        cur_pin_value = pin_value;
        cur_pin_index = pin_index;
        cmd_valid     = 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_add();
        send_item($urandom_range(1) ? OP_WRITE : OP_READ,
                  16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                  1'b0, 16'h0000, 10'd0);
    endtask

    // End the run on a stretch with no handshake on either channel.
    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int phase_end;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        opcode         = OP_BEGIN;
        reg_address    = '0;
        write_value    = '0;
        cur_pinned     = 1'b0;
        cur_pin_value  = '0;
        cur_pin_index  = '0;
        seg_len        = '0;
        seg_crc        = CRC_INIT;
        errors         = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table with no idling on either side.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_item(directed_rows[r].op, directed_rows[r].adr, directed_rows[r].dat,
                      directed_rows[r].pinned, directed_rows[r].pin_value,
                      directed_rows[r].pin_index);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = phase_send_pct[phase];
            recv_stall_pct = phase_stall_pct[phase];
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(99) < 80)
                begin
                    // Well-formed segment with random content; drop the end
                    // now and then so the next begin lands mid-segment.
                    send_item(OP_BEGIN, 16'($urandom_range(16'hFFFF)),
                              16'($urandom_range(16'hFFFF)), 1'b0, 16'h0000, 10'd0);
                    repeat ($urandom_range(8)) send_random_add();
                    if ($urandom_range(99) < 90)
                    begin
                        send_item(OP_END, 16'($urandom_range(16'hFFFF)),
                                  16'($urandom_range(16'hFFFF)), 1'b0, 16'h0000, 10'd0);
                    end
                end
                else
                begin
                    // Noise: any opcode, any payload.
                    send_item(2'($urandom_range(3)), 16'($urandom_range(16'hFFFF)),
                              16'($urandom_range(16'hFFFF)), 1'b0, 16'h0000, 10'd0);
                end
            end
            if (phase == 3)
            begin
                // Fill one segment to the top, run past it into overflow,
                // then close it and try an add on the fresh segment.
                send_item(OP_BEGIN, 16'h0000, 16'h0000, 1'b0, 16'h0000, 10'd0);
                repeat (FILL_ADDS) send_random_add();
                send_item(OP_END, 16'h0000, 16'h0000, 1'b0, 16'h0000, 10'd0);
                send_random_add();
                send_item(OP_END, 16'h0000, 16'h0000, 1'b0, 16'h0000, 10'd0);
            end
        end

        cmd_valid = 1'b0;

        // Drain: wait for every expected word, then watch for strays.
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_words.size() != 0)
            report_mismatch("words never delivered", pending_words.size(), 0);

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
